### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// property templates for the gfau port checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GFAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfau assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define GFAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gfau assertion failed");

`endif

### hw/rtl/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// widths, codes and control types shared by the gf(2^m) arithmetic unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfau_pkg;

  // field size limits
  localparam int MAX_FIELD_BITS = 16;
  localparam int ELEM_W = MAX_FIELD_BITS;
  localparam int POLY_W = MAX_FIELD_BITS + 1;
  localparam int DEG_W  = $clog2(MAX_FIELD_BITS + 1);
  localparam int IDX_W  = $clog2(MAX_FIELD_BITS);

  // fixed item field widths
  localparam int EXP_W  = 32;
  localparam int CNT_W  = $clog2(EXP_W);
  localparam int RES_W  = 16;
  localparam int OPND_W = 16;
  localparam int ACT_W  = 2;
  localparam int CFG_W  = 17;

  localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(69643);

  // action codes
  localparam logic [ACT_W-1:0] ACT_MUL  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POW  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SQRT = 2'd2;

  // micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_FETCH,
    UOP_MUL_AB,
    UOP_MUL_SQ,
    UOP_MUL_BASE,
    UOP_RED_STEP,
    UOP_RED_FIX,
    UOP_DEC,
    UOP_SQRT_INIT,
    UOP_EMIT
  } uop_t;

  // branch conditions
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_M_ZERO,
    COND_ACT_MUL,
    COND_ACT_POW,
    COND_ACT_SQRT,
    COND_BASE_ZERO,
    COND_EBIT_ZERO,
    COND_CNT_ZERO,
    COND_CNT_MORE
  } cond_t;

  // sequencer to datapath
  typedef struct packed {
    uop_t uop;
    logic fetch;
  } gfau_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic             hold;
    logic             m_zero;
    logic [ACT_W-1:0] act;
    logic             base_zero;
    logic             ebit_zero;
    logic             cnt_zero;
  } gfau_status_t;

endpackage

### hw/rtl/gfau_mul.sv
// ----------------------------------------------------------------------------
// gfau_mul
// bit-serial gf(2^m) multiplier, one bit of x per cycle, msb first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfau_mul import gfau_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DEG_W-1:0]  deg,
  input  logic [POLY_W-1:0] poly,
  input  logic [ELEM_W-1:0] x,
  input  logic [ELEM_W-1:0] y,
  output logic              done,
  output logic [ELEM_W-1:0] prod
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DEG_W-1:0]  cnt_r, cnt_nxt;
  logic [ELEM_W-1:0] x_r, y_r, acc_r;
  logic [POLY_W-1:0] sh;
  logic [DEG_W-1:0]  bit_pos;
  logic [ELEM_W-1:0] step;

  // one shift, reduce and conditional add
  always_comb begin
    sh = {acc_r, 1'b0};
    if (sh[deg]) begin
      sh = sh ^ poly;
    end
    bit_pos = cnt_r - 1'b1;
    if (x_r[bit_pos[IDX_W-1:0]]) begin
      step = sh[ELEM_W-1:0] ^ y_r;
    end else begin
      step = sh[ELEM_W-1:0];
    end
  end

  // step control
  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = deg;
    end else if (run_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DEG_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= step;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### hw/rtl/gfau_useq.sv
// ----------------------------------------------------------------------------
// gfau_useq
// microcode store, step counter and branch logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfau_useq import gfau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  gfau_status_t status,
  output gfau_ctrl_t   ctrl
);

  localparam int PC_W = 5;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // program addresses
  localparam logic [PC_W-1:0] L_FETCH = 5'd0;
  localparam logic [PC_W-1:0] L_MUL   = 5'd5;
  localparam logic [PC_W-1:0] L_POW   = 5'd6;
  localparam logic [PC_W-1:0] L_RED   = 5'd7;
  localparam logic [PC_W-1:0] L_PLOOP = 5'd9;
  localparam logic [PC_W-1:0] L_PDEC  = 5'd12;
  localparam logic [PC_W-1:0] L_SQRT  = 5'd14;
  localparam logic [PC_W-1:0] L_SLOOP = 5'd15;
  localparam logic [PC_W-1:0] L_EMIT  = 5'd17;

  function automatic uword_t rom(input logic [PC_W-1:0] a);
    uword_t w;
    case (a)
      // fetch and dispatch
      5'd0:  w = '{UOP_FETCH,     COND_M_ZERO,    L_EMIT};
      5'd1:  w = '{UOP_NOP,       COND_ACT_MUL,   L_MUL};
      5'd2:  w = '{UOP_NOP,       COND_ACT_POW,   L_POW};
      5'd3:  w = '{UOP_NOP,       COND_ACT_SQRT,  L_SQRT};
      5'd4:  w = '{UOP_NOP,       COND_ALWAYS,    L_EMIT};
      // product
      5'd5:  w = '{UOP_MUL_AB,    COND_ALWAYS,    L_EMIT};
      // power: reduce exponent, then square and multiply
      5'd6:  w = '{UOP_NOP,       COND_BASE_ZERO, L_EMIT};
      5'd7:  w = '{UOP_RED_STEP,  COND_CNT_MORE,  L_RED};
      5'd8:  w = '{UOP_RED_FIX,   COND_NEVER,     L_FETCH};
      5'd9:  w = '{UOP_MUL_SQ,    COND_NEVER,     L_FETCH};
      5'd10: w = '{UOP_NOP,       COND_EBIT_ZERO, L_PDEC};
      5'd11: w = '{UOP_MUL_BASE,  COND_NEVER,     L_FETCH};
      5'd12: w = '{UOP_DEC,       COND_CNT_MORE,  L_PLOOP};
      5'd13: w = '{UOP_NOP,       COND_ALWAYS,    L_EMIT};
      // square root: m-1 squarings
      5'd14: w = '{UOP_SQRT_INIT, COND_NEVER,     L_FETCH};
      5'd15: w = '{UOP_DEC,       COND_CNT_ZERO,  L_EMIT};
      5'd16: w = '{UOP_MUL_SQ,    COND_ALWAYS,    L_SLOOP};
      // hand over result
      5'd17: w = '{UOP_EMIT,      COND_ALWAYS,    L_FETCH};
      default: w = '{UOP_NOP,     COND_ALWAYS,    L_FETCH};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          word;
  logic            take;

  // branch evaluation on current datapath state
  always_comb begin
    word = rom(pc_r);
    case (word.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_M_ZERO:    take = status.m_zero;
      COND_ACT_MUL:   take = (status.act == ACT_MUL);
      COND_ACT_POW:   take = (status.act == ACT_POW);
      COND_ACT_SQRT:  take = (status.act == ACT_SQRT);
      COND_BASE_ZERO: take = status.base_zero;
      COND_EBIT_ZERO: take = status.ebit_zero;
      COND_CNT_ZERO:  take = status.cnt_zero;
      COND_CNT_MORE:  take = !status.cnt_zero;
      default:        take = 1'b0;
    endcase
    pc_nxt = pc_r;
    if (!status.hold) begin
      pc_nxt = take ? word.target : pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= L_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.uop   = word.uop;
  assign ctrl.fetch = (word.uop == UOP_FETCH);

endmodule

### hw/rtl/gf2m_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit
// gf(2^m) multiply, power and square root, m set by a field polynomial register
// ----------------------------------------------------------------------------
// usage:
//   cfg_write with cfg_field_polynomial loads the field polynomial; its top
//   set bit gives m (up to 16). write it only while no item is in flight.
//   input items transfer when in_valid is high and in_stall is low; in_stall
//   is low only while the sequencer waits at its fetch step.
//   each item gives exactly one result on out_valid/out_result, which holds
//   until a cycle with out_stall low. a waiting result does not block the
//   next input transfer; a stalled output only parks the sequencer at its
//   final step.
//   one item is worked on at a time; the next input transfer waits until
//   the sequencer is back at its fetch step.
//   reset restores polynomial 0x1100B (m = 16), empties the output register
//   and returns the sequencer to its fetch step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gf2m_arithmetic_unit import gfau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_write,
  input  logic [CFG_W-1:0]        cfg_field_polynomial,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [OPND_W-1:0]       in_operand_a,
  input  logic [OPND_W-1:0]       in_operand_b,
  input  logic signed [EXP_W-1:0] in_exponent,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RES_W-1:0]        out_result
);

  gfau_ctrl_t   ctrl;
  gfau_status_t status;

  logic [POLY_W-1:0] poly_r;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [ELEM_W-1:0] base_r, base_nxt;
  logic [ELEM_W-1:0] opb_r, opb_nxt;
  logic              neg_r, neg_nxt;
  logic [EXP_W-1:0]  mag_r, mag_nxt;
  logic [ELEM_W-1:0] r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ELEM_W-1:0] acc_r, acc_nxt;
  logic              mul_wait_r, mul_wait_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]  out_result_r, out_result_nxt;

  logic [DEG_W-1:0]  deg;
  logic [ELEM_W-1:0] mask;
  logic [EXP_W-1:0]  exp_u;
  logic [ELEM_W:0]   red_t;
  logic              hold;
  logic              mul_start;
  logic              mul_done;
  logic [ELEM_W-1:0] mul_x, mul_y, mul_prod;

  // field degree: highest set polynomial bit above bit 0
  always_comb begin
    deg = '0;
    for (int i = 1; i <= MAX_FIELD_BITS; i++) begin
      if (poly_r[i]) begin
        deg = DEG_W'(i);
      end
    end
  end

  // element mask: bit i kept when the polynomial has a bit above i
  always_comb begin
    for (int i = 0; i < ELEM_W; i++) begin
      mask[i] = ((poly_r >> (i + 1)) != '0);
    end
  end

  // polynomial register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
    end else if (cfg_write) begin
      poly_r <= cfg_field_polynomial[POLY_W-1:0];
    end
  end

  gfau_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  gfau_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .deg   (deg),
    .poly  (poly_r),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign exp_u = $unsigned(in_exponent);
  // one restoring step of exponent mod (2^m - 1)
  assign red_t = {r_r, mag_r[EXP_W-1]};

  // datapath decode of the current micro-operation
  always_comb begin
    act_nxt        = act_r;
    base_nxt       = base_r;
    opb_nxt        = opb_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    r_nxt          = r_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    mul_wait_nxt   = mul_wait_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r;
    hold           = 1'b0;
    mul_start      = 1'b0;
    mul_x          = acc_r;
    mul_y          = acc_r;

    // result transfer frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (ctrl.uop)
      UOP_FETCH: begin
        if (in_valid) begin
          act_nxt  = in_action;
          base_nxt = in_operand_a[ELEM_W-1:0] & mask;
          opb_nxt  = in_operand_b[ELEM_W-1:0] & mask;
          neg_nxt  = exp_u[EXP_W-1];
          mag_nxt  = exp_u[EXP_W-1] ? (~exp_u + 1'b1) : exp_u;
          r_nxt    = '0;
          cnt_nxt  = CNT_W'(EXP_W - 1);
          acc_nxt  = '0;
        end else begin
          hold = 1'b1;
        end
      end
      UOP_MUL_AB, UOP_MUL_SQ, UOP_MUL_BASE: begin
        if (ctrl.uop == UOP_MUL_AB) begin
          mul_x = base_r;
          mul_y = opb_r;
        end else if (ctrl.uop == UOP_MUL_BASE) begin
          mul_y = base_r;
        end
        if (!mul_wait_r) begin
          mul_start    = 1'b1;
          mul_wait_nxt = 1'b1;
          hold         = 1'b1;
        end else if (mul_done) begin
          acc_nxt      = mul_prod;
          mul_wait_nxt = 1'b0;
        end else begin
          hold = 1'b1;
        end
      end
      UOP_RED_STEP: begin
        if (red_t >= {1'b0, mask}) begin
          r_nxt = ELEM_W'(red_t - {1'b0, mask});
        end else begin
          r_nxt = red_t[ELEM_W-1:0];
        end
        mag_nxt = {mag_r[EXP_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      UOP_RED_FIX: begin
        if (neg_r && (r_r != '0)) begin
          r_nxt = mask - r_r;
        end
        acc_nxt = ELEM_W'(1);
        cnt_nxt = CNT_W'(deg - 1'b1);
      end
      UOP_DEC: begin
        cnt_nxt = cnt_r - 1'b1;
      end
      UOP_SQRT_INIT: begin
        acc_nxt = base_r;
        cnt_nxt = CNT_W'(deg - 1'b1);
      end
      UOP_EMIT: begin
        if (out_valid_r && out_stall) begin
          hold = 1'b1;
        end else begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = RES_W'(acc_r & mask);
        end
      end
      default: begin
      end
    endcase
  end

  // status back to the sequencer
  assign status.hold      = hold;
  assign status.m_zero    = (deg == '0);
  assign status.act       = act_r;
  assign status.base_zero = (base_r == '0);
  assign status.ebit_zero = !r_r[cnt_r[IDX_W-1:0]];
  assign status.cnt_zero  = (cnt_r == '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_wait_r  <= mul_wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    base_r       <= base_nxt;
    opb_r        <= opb_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    r_r          <= r_nxt;
    cnt_r        <= cnt_nxt;
    acc_r        <= acc_nxt;
    out_result_r <= out_result_nxt;
  end

  assign in_stall   = !ctrl.fetch;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

### hw/rtl/gfau_checker.sv
// ----------------------------------------------------------------------------
// gfau_checker
// port-level checks for the gf(2^m) arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gfau_checker import gfau_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RES_W-1:0] out_result
);

  // a stalled result stays offered and unchanged
  `GFAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `GFAU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_result))

  // an input transfer starts work, so the next item is held off
  `GFAU_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

  // a new result only comes out of a working sequencer
  `GFAU_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind gf2m_arithmetic_unit gfau_checker u_gfau_checker (.*);
